>>> rtl/counting_sort_engine_defines.svh
// Assertion macros shared by the counting sort engine.
`ifndef COUNTING_SORT_ENGINE_DEFINES_SVH
`define COUNTING_SORT_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cse_pkg.sv
package cse_pkg;

  localparam int VAL_W   = 14;
  localparam int COUNT_W = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TAKE   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_DROPPED = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic ins_rd;
    logic ins_wr;
    logic scan_init;
    logic scan_rd;
    logic scan_next;
    logic take_wr;
    logic res_err;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic is_take;
    logic drop;
    logic empty;
    logic rd_zero;
    logic scan_last;
  } stat_t;

endpackage

>>> rtl/cse_in_if.sv
interface cse_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [cse_pkg::VAL_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

>>> rtl/cse_out_if.sv
interface cse_out_if;
  logic                      valid;
  logic                      ready;
  logic [cse_pkg::VAL_W-1:0] sorted_value;
  logic [1:0]                status;
  logic                      is_last;

  modport source (output valid, output sorted_value, output status, output is_last,
                  input ready);
  modport sink (input valid, input sorted_value, input status, input is_last,
                output ready);
endinterface

>>> rtl/cse_ctrl.sv
module cse_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cse_pkg::stat_t stat_i,
  output cse_pkg::cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_DECODE   = 9'b000000100,
    S_INS_RD   = 9'b000001000,
    S_INS_WR   = 9'b000010000,
    S_SCAN_RD  = 9'b000100000,
    S_SCAN_CHK = 9'b001000000,
    S_TAKE_WR  = 9'b010000000,
    S_RESP_ERR = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.is_take) begin
          if (stat_i.empty) begin
            state_d = S_RESP_ERR;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN_RD;
          end
        end else if (stat_i.drop) begin
          state_d = S_RESP_ERR;
        end else begin
          state_d = S_INS_RD;
        end
      end
      S_INS_RD: begin
        cmd_o.ins_rd = 1'b1;
        state_d      = S_INS_WR;
      end
      S_INS_WR: begin
        if (stat_i.out_free) begin
          cmd_o.ins_wr = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (!stat_i.rd_zero) begin
          state_d = S_TAKE_WR;
        end else if (stat_i.scan_last) begin
          // Nothing left above the pointer: report the take as empty.
          state_d = S_RESP_ERR;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = S_SCAN_RD;
        end
      end
      S_TAKE_WR: begin
        if (stat_i.out_free) begin
          cmd_o.take_wr = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_RESP_ERR: begin
        if (stat_i.out_free) begin
          cmd_o.res_err = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/cse_datapath.sv
module cse_datapath #(
  parameter int VALUE_COUNT = 16384,
  parameter int MAX_ITEMS   = 65535
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cse_pkg::cmd_t             cmd_i,
  output cse_pkg::stat_t            stat_o,
  input  logic                      in_operation_i,
  input  logic [cse_pkg::VAL_W-1:0] in_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [cse_pkg::VAL_W-1:0] out_sorted_value_o,
  output logic [1:0]                out_status_o,
  output logic                      out_is_last_o
);

  localparam int IDX_W = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VALUE_COUNT - 1);

  logic [cse_pkg::COUNT_W-1:0] mem [VALUE_COUNT];

  logic [IDX_W-1:0]            clr_q;
  logic [IDX_W-1:0]            ptr_q;
  logic [IDX_W-1:0]            scan_q;
  logic [cse_pkg::COUNT_W-1:0] items_q;
  logic                        out_valid_q;

  logic                        op_q;
  logic [cse_pkg::VAL_W-1:0]   value_q;
  logic [cse_pkg::COUNT_W-1:0] rdata_q;
  logic [cse_pkg::VAL_W-1:0]   res_value_q;
  cse_pkg::status_e            res_status_q;
  logic                        res_last_q;

  logic [IDX_W-1:0]            val_idx;
  logic                        mem_we;
  logic                        mem_re;
  logic [IDX_W-1:0]            mem_waddr;
  logic [IDX_W-1:0]            mem_raddr;
  logic [cse_pkg::COUNT_W-1:0] mem_wdata;
  logic                        res_load;

  // Only values that passed the range check reach the memory, so the cast is lossless.
  assign val_idx  = IDX_W'(value_q);
  assign res_load = cmd_i.ins_wr | cmd_i.take_wr | cmd_i.res_err;

  assign mem_we    = cmd_i.clr_wr | cmd_i.ins_wr | cmd_i.take_wr;
  assign mem_re    = cmd_i.ins_rd | cmd_i.scan_rd;
  assign mem_raddr = cmd_i.ins_rd ? val_idx : scan_q;

  always_comb begin
    if (cmd_i.clr_wr) begin
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (cmd_i.ins_wr) begin
      mem_waddr = val_idx;
      mem_wdata = rdata_q + cse_pkg::COUNT_W'(1);
    end else begin
      mem_waddr = scan_q;
      mem_wdata = rdata_q - cse_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      ptr_q       <= '0;
      scan_q      <= '0;
      items_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (cmd_i.scan_init) begin
        scan_q <= ptr_q;
      end else if (cmd_i.scan_next) begin
        scan_q <= scan_q + IDX_W'(1);
      end
      if (cmd_i.ins_wr) begin
        items_q <= items_q + cse_pkg::COUNT_W'(1);
        if (val_idx < ptr_q) begin
          ptr_q <= val_idx;
        end
      end else if (cmd_i.take_wr) begin
        items_q <= items_q - cse_pkg::COUNT_W'(1);
        ptr_q   <= scan_q;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= in_operation_i;
      value_q <= in_value_i;
    end
    if (cmd_i.take_wr) begin
      res_value_q  <= cse_pkg::VAL_W'(scan_q);
      res_status_q <= cse_pkg::ST_OK;
      res_last_q   <= (items_q == cse_pkg::COUNT_W'(1));
    end else if (cmd_i.ins_wr) begin
      res_value_q  <= '0;
      res_status_q <= cse_pkg::ST_OK;
      res_last_q   <= 1'b0;
    end else if (cmd_i.res_err) begin
      res_value_q  <= '0;
      res_status_q <= (op_q == cse_pkg::OP_TAKE) ? cse_pkg::ST_EMPTY : cse_pkg::ST_DROPPED;
      res_last_q   <= 1'b0;
    end
  end

  assign stat_o.clr_last  = (clr_q == LAST_IDX);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.is_take   = (op_q == cse_pkg::OP_TAKE);
  assign stat_o.drop      = (32'(items_q) >= MAX_ITEMS) || (32'(value_q) >= VALUE_COUNT);
  assign stat_o.empty     = (items_q == '0);
  assign stat_o.rd_zero   = (rdata_q == '0);
  assign stat_o.scan_last = (scan_q == LAST_IDX);

  assign out_valid_o        = out_valid_q;
  assign out_sorted_value_o = res_value_q;
  assign out_status_o       = 2'(res_status_q);
  assign out_is_last_o      = res_last_q;

endmodule

>>> rtl/counting_sort_engine.sv
// Insert: after the input transfer the bin is read, then incremented as the result is loaded.
// Take: bins are read upward from the pointer until a nonzero one, which is decremented as its
// value is loaded; each empty bin skipped costs another read of the single registered read port
// of the bin memory. An error result (dropped insert, take on empty store) is loaded after decode.
// Loads wait for a free output slot; the next item is taken only once the result is loaded. After
// reset a clearing pass writes zero to every bin, with input ready held low until it completes.
`include "counting_sort_engine_defines.svh"

module counting_sort_engine #(
  parameter int VALUE_COUNT = 16384,
  parameter int MAX_ITEMS   = 65535
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cse_in_if.sink    req_i,
  cse_out_if.source rsp_o
);

  cse_pkg::cmd_t  cmd;
  cse_pkg::stat_t stat;
  logic           in_ready;

  assign req_i.ready = in_ready;

  cse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cse_datapath #(
    .VALUE_COUNT (VALUE_COUNT),
    .MAX_ITEMS   (MAX_ITEMS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .in_operation_i     (req_i.operation),
    .in_value_i         (req_i.value),
    .out_valid_o        (rsp_o.valid),
    .out_ready_i        (rsp_o.ready),
    .out_sorted_value_o (rsp_o.sorted_value),
    .out_status_o       (rsp_o.status),
    .out_is_last_o      (rsp_o.is_last)
  );

  // A counter update may only happen when its result can be loaded at once.
  `CSE_ASSERT_SAME(a_wr_needs_slot, cmd.ins_wr || cmd.take_wr, stat.out_free, "output slot busy")
  // A take never decrements an empty bin.
  `CSE_ASSERT_SAME(a_take_nonzero, cmd.take_wr, !stat.rd_zero, "take from empty bin")
  // No transfer is taken while the clearing pass runs.
  `CSE_ASSERT_SAME(a_no_accept_clear, cmd.clr_wr, !req_i.ready, "input ready during clear")
  // Loading a result always leaves a valid result on the output.
  `CSE_ASSERT_NEXT(a_result_shown, cmd.ins_wr || cmd.take_wr || cmd.res_err, rsp_o.valid, "result lost")

endmodule
